@@ hdl/i2cram_pkg.sv @@
// i2cram_pkg: shared types, command codes and slot line patterns for the
// i2c register access master. No dependencies.
package i2cram_pkg;

    localparam int CNT_W = 7;

    localparam logic [1:0] CMD_TICK       = 2'd0;
    localparam logic [1:0] CMD_WRITE      = 2'd1;
    localparam logic [1:0] CMD_READ_BYTE  = 2'd2;
    localparam logic [1:0] CMD_READ_WORD  = 2'd3;

    localparam logic [CNT_W-1:0] WRITE_SLOTS = 7'd60;
    localparam logic [CNT_W-1:0] READ_SLOTS  = 7'd81;

    localparam logic [7:0] READ_BIT = 8'h01;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] target_reg;
        logic [7:0] write_data;
        logic       sda_sampled;
    } t_item;

    typedef struct packed {
        logic        scl_level;
        logic        sda_level;
        logic        sda_drive_enable;
        logic        busy_res;
        logic        done_res;
        logic [15:0] read_value;
        logic        nack_seen;
    } t_result;

    // {scl, sda, drive} for the three slots of a start condition
    function automatic logic [2:0] start_lines(input logic [1:0] off);
        logic [2:0] v;
        case (off)
            2'd0:    v = 3'b111;
            2'd1:    v = 3'b101;
            default: v = 3'b001;
        endcase
        return v;
    endfunction

    // stop raises scl before sda
    function automatic logic [2:0] stop_lines(input logic [1:0] off);
        logic [2:0] v;
        case (off)
            2'd0:    v = 3'b001;
            2'd1:    v = 3'b101;
            default: v = 3'b111;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/i2cram_in_if.sv @@
// i2cram_in_if: valid/ready channel carrying one tick item into the master.
// No dependencies.
interface i2cram_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] target_reg;
    logic [7:0] write_data;
    logic       sda_sampled;

    modport source (output valid, cmd, target_reg, write_data, sda_sampled, input ready);
    modport sink   (input valid, cmd, target_reg, write_data, sda_sampled, output ready);
endinterface

@@ hdl/i2cram_out_if.sv @@
// i2cram_out_if: valid/ready channel carrying one bus slot result out.
// No dependencies.
interface i2cram_out_if;
    logic        valid;
    logic        ready;
    logic        scl_level;
    logic        sda_level;
    logic        sda_drive_enable;
    logic        busy_res;
    logic        done_res;
    logic [15:0] read_value;
    logic        nack_seen;

    modport source (output valid, scl_level, sda_level, sda_drive_enable, busy_res,
                    done_res, read_value, nack_seen, input ready);
    modport sink   (input valid, scl_level, sda_level, sda_drive_enable, busy_res,
                    done_res, read_value, nack_seen, output ready);
endinterface

@@ hdl/i2cram_seq.sv @@
// i2cram_seq: slot sequencer holding the transaction state; works out the
// pin levels and flags of one slot per enabled tick. Uses i2cram_pkg.
module i2cram_seq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  i2cram_pkg::t_item   i_item,
    input  logic [7:0]          i_dev_addr,
    output i2cram_pkg::t_result o_res
);
    import i2cram_pkg::*;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_kind, n_kind;
    logic             r_phase, n_phase;
    logic [7:0]       r_reg, n_reg;
    logic [7:0]       r_data, n_data;
    logic [7:0]       r_sh, n_sh;
    logic [15:0]      r_rr, n_rr;
    logic             r_nack, n_nack;

    always_comb begin
        logic             start;
        logic [CNT_W-1:0] p;
        logic [CNT_W-1:0] len;
        logic [2:0]       lines;
        logic             send_en;
        logic [7:0]       send_b;
        logic [4:0]       send_off;
        logic             recv_en;
        logic [3:0]       recv_off;
        logic             busy;
        logic             done;

        start = (r_cnt == '0) && (i_item.cmd != CMD_TICK);
        n_kind  = start ? i_item.cmd         : r_kind;
        n_reg   = start ? i_item.target_reg  : r_reg;
        n_data  = start ? i_item.write_data  : r_data;
        n_phase = start ? 1'b0 : r_phase;
        n_nack  = start ? 1'b0 : r_nack;
        n_sh    = start ? 8'h00 : r_sh;
        n_rr    = r_rr;
        p       = start ? CNT_W'(1) : r_cnt;
        n_cnt   = p;

        lines    = 3'b110;
        send_en  = 1'b0;
        send_b   = i_dev_addr;
        send_off = '0;
        recv_en  = 1'b0;
        recv_off = '0;
        busy     = 1'b0;
        done     = 1'b0;
        len      = (n_kind == CMD_WRITE) ? WRITE_SLOTS : READ_SLOTS;

        if (p != '0) begin
            busy = 1'b1;
            if (p <= 7'd3) begin
                lines = start_lines(2'(p - 7'd1));
            end else if (n_kind == CMD_WRITE) begin
                if (p <= 7'd57) begin
                    send_en = 1'b1;
                    if (p <= 7'd21) begin
                        send_b   = i_dev_addr;
                        send_off = 5'(p - 7'd4);
                    end else if (p <= 7'd39) begin
                        send_b   = n_reg;
                        send_off = 5'(p - 7'd22);
                    end else begin
                        send_b   = n_data;
                        send_off = 5'(p - 7'd40);
                    end
                end else if (p <= WRITE_SLOTS) begin
                    lines = stop_lines(2'(p - 7'd58));
                end
            end else begin
                if (p <= 7'd21) begin
                    send_en  = 1'b1;
                    send_b   = i_dev_addr;
                    send_off = 5'(p - 7'd4);
                end else if (p <= 7'd39) begin
                    send_en  = 1'b1;
                    send_b   = n_reg + {7'd0, n_phase};
                    send_off = 5'(p - 7'd22);
                end else if (p <= 7'd42) begin
                    lines = start_lines(2'(p - 7'd40));
                end else if (p <= 7'd60) begin
                    send_en  = 1'b1;
                    send_b   = i_dev_addr + READ_BIT;
                    send_off = 5'(p - 7'd43);
                end else if (p <= 7'd76) begin
                    recv_en  = 1'b1;
                    recv_off = 4'(p - 7'd61);
                end else if (p <= 7'd78) begin
                    // master nack: sda held high by the master
                    lines = {p != 7'd77, 2'b11};
                end else if (p <= READ_SLOTS) begin
                    lines = stop_lines(2'(p - 7'd79));
                end
            end

            if (send_en) begin
                if (!send_off[4]) begin
                    lines = {send_off[0], send_b[3'd7 - send_off[3:1]], 1'b1};
                end else begin
                    // acknowledge pair, sampled on the high slot
                    lines = {send_off[0], 2'b10};
                    if (send_off[0] && i_item.sda_sampled) begin
                        n_nack = 1'b1;
                    end
                end
            end

            if (recv_en) begin
                lines = {recv_off[0], 2'b10};
                if (recv_off[0]) begin
                    n_sh = {n_sh[6:0], i_item.sda_sampled};
                    if (recv_off[3:1] == 3'd7) begin
                        if (n_kind == CMD_READ_WORD) begin
                            n_rr = n_phase ? {r_rr[15:8], n_sh} : {n_sh, 8'h00};
                        end else begin
                            n_rr = {8'h00, n_sh};
                        end
                    end
                end
            end

            if (p >= len) begin
                if (n_kind == CMD_READ_WORD && !n_phase) begin
                    n_phase = 1'b1;
                    n_cnt   = CNT_W'(1);
                end else begin
                    n_cnt = '0;
                    done  = 1'b1;
                end
            end else begin
                n_cnt = p + CNT_W'(1);
            end
        end

        o_res.scl_level        = lines[2];
        o_res.sda_level        = lines[1];
        o_res.sda_drive_enable = lines[0];
        o_res.busy_res         = busy;
        o_res.done_res         = done;
        o_res.read_value       = n_rr;
        o_res.nack_seen        = n_nack;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt   <= '0;
            r_kind  <= CMD_TICK;
            r_phase <= 1'b0;
            r_reg   <= '0;
            r_data  <= '0;
            r_sh    <= '0;
            r_rr    <= '0;
            r_nack  <= 1'b0;
        end else if (i_en) begin
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
            r_phase <= n_phase;
            r_reg   <= n_reg;
            r_data  <= n_data;
            r_sh    <= n_sh;
            r_rr    <= n_rr;
            r_nack  <= n_nack;
        end
    end

`ifndef SYNTHESIS
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.done_res |-> o_res.busy_res)
        else $error("done without busy");

    a_idle_lines: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_res.busy_res |-> (o_res.scl_level && o_res.sda_level && !o_res.sda_drive_enable))
        else $error("bus not released while idle");

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && o_res.done_res) |=> (r_cnt == '0))
        else $error("sequencer not idle after done");

    a_tick_stays_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_en && r_cnt == '0 && i_item.cmd == CMD_TICK) |=> (r_cnt == '0))
        else $error("plain tick left idle");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= READ_SLOTS)
        else $error("slot counter out of range");
`endif

endmodule

@@ hdl/i2c_register_access_master.sv @@
// Each accepted tick item advances the I2C bus by one timing slot and gives exactly one
// result item with the SCL/SDA levels for that slot, busy, done, the read value and the
// sticky nack flag. One item per clock cycle is taken when the result side keeps up; a
// result is offered once its item has passed the input register and then the result
// register, which holds the slot, and the slot sequencer updates its state once per
// item. A register write takes 60 ticks, a byte read 81 and a word read 162; commands
// while busy are ignored.
// Top level of the i2c register access master; uses i2cram_pkg, i2cram_in_if,
// i2cram_out_if and i2cram_seq.
module i2c_register_access_master (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [7:0]   i_cfg_wr_data,
    i2cram_in_if.sink    i_item,
    i2cram_out_if.source o_res
);
    import i2cram_pkg::*;

    localparam logic [7:0] DEV_ADDR_RESET = 8'd208;

    logic [7:0] r_dev_addr;
    logic       r_in_valid;
    t_item      r_in;
    logic       r_out_valid;
    t_result    r_out;
    t_result    seq_res;
    logic       advance;

    assign advance      = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_item.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dev_addr <= DEV_ADDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_dev_addr <= i_cfg_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_item.valid && i_item.ready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_in.cmd         <= i_item.cmd;
            r_in.target_reg  <= i_item.target_reg;
            r_in.write_data  <= i_item.write_data;
            r_in.sda_sampled <= i_item.sda_sampled;
        end
    end

    i2cram_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (advance),
        .i_item     (r_in),
        .i_dev_addr (r_dev_addr),
        .o_res      (seq_res)
    );

    // result register: holds a finished slot while the sink stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= seq_res;
        end
    end

    assign o_res.valid            = r_out_valid;
    assign o_res.scl_level        = r_out.scl_level;
    assign o_res.sda_level        = r_out.sda_level;
    assign o_res.sda_drive_enable = r_out.sda_drive_enable;
    assign o_res.busy_res         = r_out.busy_res;
    assign o_res.done_res         = r_out.done_res;
    assign o_res.read_value       = r_out.read_value;
    assign o_res.nack_seen        = r_out.nack_seen;

endmodule

@@ dv/i2cram_slot_checker.sv @@
`timescale 1ns / 100ps
// i2cram_slot_checker: watches the tick and result channels of the i2c register
// access master, predicts every bus slot and compares it field by field.
// Depends on i2cram_pkg, i2cram_in_if and i2cram_out_if.
module i2cram_slot_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [7:0] i_cfg_wr_data,
    i2cram_in_if       i_item,
    i2cram_out_if      i_res,
    output int         o_fail_count,
    output int         o_outstanding,
    output int         o_writes,
    output int         o_byte_reads,
    output int         o_word_reads,
    output int         o_nacked
);
    import i2cram_pkg::*;

    localparam int         WR_LEN         = 60;
    localparam int         RD_LEN         = 81;
    localparam logic [7:0] DEV_ADDR_RESET = 8'hD0;

    // copy of the sequencer state
    logic [7:0]  dev_addr;
    int unsigned slot_no;
    logic [7:0]  rx_shift;
    logic [15:0] rd_value;
    logic        nack_q;
    logic [1:0]  op_kind;
    logic        second_half;
    logic [7:0]  reg_held;
    logic [7:0]  data_held;
    logic [2:0]  lines;     // {scl, sda, drive}

    t_result expected_slots[$];
    int fail_count = 0;
    int n_writes = 0;
    int n_byte_reads = 0;
    int n_word_reads = 0;
    int n_nacked = 0;

    assign o_fail_count = fail_count;
    assign o_writes     = n_writes;
    assign o_byte_reads = n_byte_reads;
    assign o_word_reads = n_word_reads;
    assign o_nacked     = n_nacked;

    function automatic logic [2:0] start_cond(input int off);
        return (off == 0) ? 3'b111 : (off == 1) ? 3'b101 : 3'b001;
    endfunction

    // scl rises first, then sda
    function automatic logic [2:0] stop_cond(input int off);
        return (off == 0) ? 3'b001 : (off == 1) ? 3'b101 : 3'b111;
    endfunction

    // offsets 0..15 carry the byte msb first, 16 and 17 the acknowledge pair
    function automatic void send_byte_slot(input logic [7:0] b, input int off,
                                           input logic sda_in);
        if (off < 16) begin
            lines = {1'(off % 2), b[7 - off / 2], 1'b1};
        end else begin
            lines = {1'(off - 16), 2'b10};
            if (off == 17 && sda_in)
                nack_q = 1'b1;
        end
    endfunction

    function automatic void take_rx_slot(input int off, input logic sda_in);
        lines = {1'(off % 2), 2'b10};
        if (off % 2 == 1) begin
            rx_shift = {rx_shift[6:0], sda_in};
            if (off / 2 == 7) begin
                if (op_kind == CMD_READ_WORD && !second_half)
                    rd_value = {rx_shift, 8'h00};
                else if (op_kind == CMD_READ_WORD)
                    rd_value[7:0] = rx_shift;
                else
                    rd_value = {8'h00, rx_shift};
            end
        end
    endfunction

    function automatic t_result predict_bus_slot(input t_item it);
        t_result    r;
        int         p;
        int         len;
        logic       busy;
        logic       done;
        logic [7:0] reg_cur;
        busy = 1'b0;
        done = 1'b0;
        if (slot_no == 0 && it.cmd != CMD_TICK) begin
            op_kind     = it.cmd;
            reg_held    = it.target_reg;
            data_held   = it.write_data;
            second_half = 1'b0;
            nack_q      = 1'b0;
            rx_shift    = 8'h00;
            slot_no     = 1;
        end
        if (slot_no == 0) begin
            lines = 3'b110;
        end else begin
            p    = slot_no;
            busy = 1'b1;
            len  = (op_kind == CMD_WRITE) ? WR_LEN : RD_LEN;
            if (op_kind == CMD_WRITE) begin
                if (p <= 3)
                    lines = start_cond(p - 1);
                else if (p <= 57)
                    send_byte_slot(((p - 4) / 18 == 0) ? dev_addr :
                                   ((p - 4) / 18 == 1) ? reg_held : data_held,
                                   (p - 4) % 18, it.sda_sampled);
                else
                    lines = stop_cond(p - 58);
            end else begin
                // second half of a word read addresses the next register
                reg_cur = reg_held + 8'(second_half);
                if (p <= 3)
                    lines = start_cond(p - 1);
                else if (p <= 39)
                    send_byte_slot(((p - 4) / 18 == 0) ? dev_addr : reg_cur,
                                   (p - 4) % 18, it.sda_sampled);
                else if (p <= 42)
                    lines = start_cond(p - 40);
                else if (p <= 60)
                    send_byte_slot(dev_addr + 8'd1, p - 43, it.sda_sampled);
                else if (p <= 76)
                    take_rx_slot(p - 61, it.sda_sampled);
                else if (p <= 78)
                    lines = {1'(p - 77), 2'b11};
                else
                    lines = stop_cond(p - 79);
            end
            if (p >= len) begin
                if (op_kind == CMD_READ_WORD && !second_half) begin
                    second_half = 1'b1;
                    slot_no     = 1;
                end else begin
                    slot_no = 0;
                    done    = 1'b1;
                    case (op_kind)
                        CMD_WRITE:     n_writes++;
                        CMD_READ_BYTE: n_byte_reads++;
                        default:       n_word_reads++;
                    endcase
                    if (nack_q)
                        n_nacked++;
                end
            end else begin
                slot_no = p + 1;
            end
        end
        r.scl_level        = lines[2];
        r.sda_level        = lines[1];
        r.sda_drive_enable = lines[0];
        r.busy_res         = busy;
        r.done_res         = done;
        r.read_value       = rd_value;
        r.nack_seen        = nack_q;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            fail_count++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            dev_addr    = DEV_ADDR_RESET;
            slot_no     = 0;
            rx_shift    = 8'h00;
            rd_value    = 16'h0000;
            nack_q      = 1'b0;
            op_kind     = CMD_TICK;
            second_half = 1'b0;
            reg_held    = 8'h00;
            data_held   = 8'h00;
            lines       = 3'b110;
            expected_slots.delete();
        end else begin
            if (i_cfg_wr_en)
                dev_addr = i_cfg_wr_data;
            // compare before pushing so a stray result never meets a fresh prediction
            if (i_res.valid && i_res.ready) begin
                got = '{scl_level: i_res.scl_level, sda_level: i_res.sda_level,
                        sda_drive_enable: i_res.sda_drive_enable,
                        busy_res: i_res.busy_res, done_res: i_res.done_res,
                        read_value: i_res.read_value, nack_seen: i_res.nack_seen};
                if (expected_slots.size() == 0) begin
                    fail_count++;
                    $error("result transaction with no slot expected");
                end else begin
                    want = expected_slots.pop_front();
                    check_field("scl_level", 16'(want.scl_level), 16'(got.scl_level));
                    check_field("sda_level", 16'(want.sda_level), 16'(got.sda_level));
                    check_field("sda_drive_enable", 16'(want.sda_drive_enable),
                                16'(got.sda_drive_enable));
                    check_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
                    check_field("done_res", 16'(want.done_res), 16'(got.done_res));
                    check_field("read_value", want.read_value, got.read_value);
                    check_field("nack_seen", 16'(want.nack_seen), 16'(got.nack_seen));
                end
            end
            if (i_item.valid && i_item.ready)
                expected_slots.push_back(predict_bus_slot(t_item'{i_item.cmd,
                    i_item.target_reg, i_item.write_data, i_item.sda_sampled}));
        end
        o_outstanding <= expected_slots.size();
    end

endmodule

@@ dv/tb_i2c_register_access_master.sv @@
`timescale 1ns / 100ps
// tb_i2c_register_access_master: drives tick items and result back-pressure into
// the i2c register access master and reports the verdict of i2cram_slot_checker.
// Depends on i2cram_pkg, both channel interfaces, i2cram_slot_checker and the block itself.
module tb_i2c_register_access_master;
    import i2cram_pkg::*;

    localparam int RUN_LIMIT_NS     = 2_000_000;
    localparam int WR_TICKS         = 60;
    localparam int RD_TICKS         = 81;
    localparam int ADDR_ACK         = 21;
    localparam int REG_ACK          = 39;
    localparam int LAST_ACK_WR      = 57;
    localparam int LAST_ACK_RD      = 60;
    localparam int NO_NACK          = 0;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_SETTLE     = 8;
    localparam int RANDOM_ITEMS     = 660;

    typedef enum int {RX_RANDOM, RX_ONES, RX_ZEROS} t_rx_fill;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       feed_valid  = 1'b0;
    t_item      feed_item   = '0;
    logic       drain_ready = 1'b0;
    logic       long_hold   = 1'b0;
    int         drain_stall_pct = 0;
    int         send_idle_pct   = 0;
    int         items_sent      = 0;
    int         hold_left       = 0;
    logic       hold_armed      = 1'b1;

    int fail_count;
    int outstanding;
    int n_writes;
    int n_byte_reads;
    int n_word_reads;
    int n_nacked;

    i2cram_in_if  item_ch();
    i2cram_out_if res_ch();

    assign item_ch.valid       = feed_valid;
    assign item_ch.cmd         = feed_item.cmd;
    assign item_ch.target_reg  = feed_item.target_reg;
    assign item_ch.write_data  = feed_item.write_data;
    assign item_ch.sda_sampled = feed_item.sda_sampled;
    assign res_ch.ready        = drain_ready;

    i2c_register_access_master uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_item        (item_ch),
        .o_res         (res_ch)
    );

    i2cram_slot_checker slot_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_wr_data (cfg_wr_data),
        .i_item        (item_ch),
        .i_res         (res_ch),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding),
        .o_writes      (n_writes),
        .o_byte_reads  (n_byte_reads),
        .o_word_reads  (n_word_reads),
        .o_nacked      (n_nacked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // result side: random stalls, plus one long hold-off counted here
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            drain_ready <= 1'b0;
            hold_left = 0;
            hold_armed = 1'b1;
        end else if (hold_left > 0) begin
            hold_left--;
            drain_ready <= 1'b0;
        end else if (long_hold && hold_armed) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_armed = 1'b0;
            drain_ready <= 1'b0;
        end else begin
            if (!long_hold)
                hold_armed = 1'b1;
            drain_ready <= ($urandom_range(99) >= drain_stall_pct);
        end
    end

    task automatic offer_item(input t_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            feed_valid <= 1'b0;
            @(posedge i_clk);
        end
        feed_valid <= 1'b1;
        feed_item  <= it;
        @(posedge i_clk);
        while (!item_ch.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    // one whole bus transfer: the command item, then a tick per remaining slot
    task automatic run_transfer(input logic [1:0] op, input logic [7:0] reg_a,
                                input logic [7:0] wdata, input int nack_at,
                                input t_rx_fill rx_fill, input int noise_pct);
        t_item it;
        int    len;
        int    total;
        int    p;
        len   = (op == CMD_WRITE) ? WR_TICKS : RD_TICKS;
        total = (op == CMD_READ_WORD) ? 2 * RD_TICKS : len;
        for (int i = 0; i < total; i++) begin
            p = i % len + 1;
            if (i == 0) begin
                it.cmd         = op;
                it.target_reg  = reg_a;
                it.write_data  = wdata;
            end else begin
                // commands while busy must be ignored
                it.cmd = ($urandom_range(99) < noise_pct) ? 2'($urandom_range(1, 3))
                                                          : CMD_TICK;
                it.target_reg  = 8'($urandom);
                it.write_data  = 8'($urandom);
            end
            if (p == ADDR_ACK || p == REG_ACK
                    || p == ((op == CMD_WRITE) ? LAST_ACK_WR : LAST_ACK_RD))
                it.sda_sampled = (p == nack_at);
            else if (op != CMD_WRITE && p >= 62 && p <= 76 && p % 2 == 0)
                it.sda_sampled = (rx_fill == RX_ONES) ? 1'b1 :
                                 (rx_fill == RX_ZEROS) ? 1'b0 : 1'($urandom);
            else
                it.sda_sampled = 1'($urandom);
            offer_item(it);
        end
    endtask

    task automatic random_transfer();
        logic [1:0] op;
        logic [7:0] reg_a;
        int         nack_at;
        int         pick;
        op   = 2'($urandom_range(1, 3));
        pick = $urandom_range(9);
        reg_a = (pick == 0) ? 8'hFF : (pick == 1) ? 8'h00 : 8'($urandom);
        nack_at = NO_NACK;
        if ($urandom_range(3) == 0) begin
            case ($urandom_range(2))
                0:       nack_at = ADDR_ACK;
                1:       nack_at = REG_ACK;
                default: nack_at = (op == CMD_WRITE) ? LAST_ACK_WR : LAST_ACK_RD;
            endcase
        end
        run_transfer(op, reg_a, 8'($urandom), nack_at, t_rx_fill'($urandom_range(2)), 15);
        repeat ($urandom_range(3))
            offer_item(t_item'{CMD_TICK, 8'($urandom), 8'($urandom), 1'($urandom)});
    endtask

    // stop offering and let every expected result come back
    task automatic wait_drained();
        feed_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0)
            @(posedge i_clk);
        repeat (DRAIN_SETTLE)
            @(posedge i_clk);
    endtask

    task automatic write_dev_addr(input logic [7:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [7:0] dev_settings [4];
        int         idle_mix [4];
        int         stall_mix [4];
        int         phase_goal;
        dev_settings = '{8'h00, 8'hFF, 8'($urandom), 8'hD0};
        idle_mix     = '{0, 65, 0, 21};
        stall_mix    = '{0, 0, 65, 21};
        repeat (2)
            @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: idle ticks at the field extremes, then each kind of transfer
        offer_item(t_item'{CMD_TICK, 8'h00, 8'h00, 1'b0});
        offer_item(t_item'{CMD_TICK, 8'hFF, 8'hFF, 1'b1});
        offer_item(t_item'{CMD_TICK, 8'hFF, 8'h00, 1'b1});
        offer_item(t_item'{CMD_TICK, 8'h00, 8'hFF, 1'b0});
        run_transfer(CMD_WRITE, 8'hFF, 8'h00, NO_NACK, RX_RANDOM, 30);
        run_transfer(CMD_WRITE, 8'h00, 8'hFF, LAST_ACK_WR, RX_RANDOM, 0);
        run_transfer(CMD_READ_BYTE, 8'h00, 8'h5A, ADDR_ACK, RX_ONES, 0);
        run_transfer(CMD_READ_BYTE, 8'h80, 8'hA5, NO_NACK, RX_ZEROS, 30);
        // register wraps from 0xff to 0x00 in the second half
        run_transfer(CMD_READ_WORD, 8'hFF, 8'h00, LAST_ACK_RD, RX_RANDOM, 10);

        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            write_dev_addr(dev_settings[ph]);
            send_idle_pct = idle_mix[ph];
            drain_stall_pct <= stall_mix[ph];
            phase_goal = items_sent + RANDOM_ITEMS / 4;
            if (ph == 0) begin
                // the block fills up and stalls its input while results are held off
                long_hold <= 1'b1;
                random_transfer();
                long_hold <= 1'b0;
            end
            while (items_sent < phase_goal)
                random_transfer();
        end
        wait_drained();

        $display("%0d ticks sent: %0d writes, %0d byte reads, %0d word reads, %0d nacked",
                 items_sent, n_writes, n_byte_reads, n_word_reads, n_nacked);
        $display("device address set to 0xd0, 0x00, 0xff, 0x%02h; four idle/stall mixes",
                 dev_settings[2]);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("run did not finish in time");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
